### hdl/dcic_pkg.sv
// ----------------------------------------------------------------------------
// dcic_pkg: shared definitions for the dual-core interrupt controller
// Command codes, register offsets and masks used by the controller logic.
// ----------------------------------------------------------------------------
package dcic_pkg;

  // Request kinds carried on the input channel
  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned OFFS_W = 12;
  localparam int unsigned SIZE_W = 3;

  // Access sizes that narrow the read data
  localparam logic [SIZE_W-1:0] SIZE_BYTE = 3'd1;
  localparam logic [SIZE_W-1:0] SIZE_HALF = 3'd2;

  localparam logic [DATA_W-1:0] MASK_BYTE = 32'h0000_00ff;
  localparam logic [DATA_W-1:0] MASK_HALF = 32'h0000_ffff;
  localparam logic [DATA_W-1:0] MASK_WORD = 32'hffff_ffff;

  // High-bank summary bit in the low status words and low enable masks
  localparam int unsigned SUMMARY_IDX = 30;

  // Register offsets (byte offsets in the device window)
  localparam logic [OFFS_W-1:0] OFF_CPU_LO_STAT = 12'h000;
  localparam logic [OFFS_W-1:0] OFF_COP_LO_STAT = 12'h004;
  localparam logic [OFFS_W-1:0] OFF_ALL_LO_STAT = 12'h010;
  localparam logic [OFFS_W-1:0] OFF_CPU_LO_EN   = 12'h020;
  localparam logic [OFFS_W-1:0] OFF_CPU_LO_SET  = 12'h024;
  localparam logic [OFFS_W-1:0] OFF_CPU_LO_CLR  = 12'h028;
  localparam logic [OFFS_W-1:0] OFF_COP_LO_EN   = 12'h030;
  localparam logic [OFFS_W-1:0] OFF_COP_LO_SET  = 12'h034;
  localparam logic [OFFS_W-1:0] OFF_COP_LO_CLR  = 12'h038;
  localparam logic [OFFS_W-1:0] OFF_CPU_HI_STAT = 12'h100;
  localparam logic [OFFS_W-1:0] OFF_COP_HI_STAT = 12'h104;
  localparam logic [OFFS_W-1:0] OFF_ALL_HI_STAT = 12'h110;
  localparam logic [OFFS_W-1:0] OFF_CPU_HI_EN   = 12'h120;
  localparam logic [OFFS_W-1:0] OFF_CPU_HI_SET  = 12'h124;
  localparam logic [OFFS_W-1:0] OFF_CPU_HI_CLR  = 12'h128;
  localparam logic [OFFS_W-1:0] OFF_COP_HI_EN   = 12'h130;
  localparam logic [OFFS_W-1:0] OFF_COP_HI_SET  = 12'h134;
  localparam logic [OFFS_W-1:0] OFF_COP_HI_CLR  = 12'h138;

  // Enable masks of both cores and both banks
  typedef struct packed {
    logic [DATA_W-1:0] cpu_lo;
    logic [DATA_W-1:0] cop_lo;
    logic [DATA_W-1:0] cpu_hi;
    logic [DATA_W-1:0] cop_hi;
  } enables_t;

  // Summary bit word: bit 30 set when a high-bank status word is nonzero
  function automatic logic [DATA_W-1:0] high_summary(input logic [DATA_W-1:0] hi);
    logic [DATA_W-1:0] w;
    w = '0;
    w[SUMMARY_IDX] = |hi;
    return w;
  endfunction

  // Core interrupt flag from its status and enable words
  function automatic logic core_flag(input logic [DATA_W-1:0] lo_st,
                                     input logic [DATA_W-1:0] lo_en,
                                     input logic [DATA_W-1:0] hi_st,
                                     input logic [DATA_W-1:0] hi_en);
    return (|(lo_st & lo_en)) || (lo_en[SUMMARY_IDX] && (|(hi_st & hi_en)));
  endfunction

endpackage

### hdl/dual_core_interrupt_controller_unit.sv
// ----------------------------------------------------------------------------
// dual_core_interrupt_controller_unit: CPU and coprocessor interrupt control
// Register reads, enable set/clear writes, IRQ ticks, one per clock when unstalled.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake            | Payload
//  --------+-----------+----------------------+---------------------------------
//  in_     | input     | in_valid / in_stall  | command, offset, size, data, status
//  out_    | output    | out_valid / out_stall| read_data, cpu_irq, cop_irq
//
//  A request is taken into the input register and its result is loaded into
//  the result register; one request is taken per clock while in_stall is low.
//  Enable masks change as a write leaves the input register, so later
//  requests see the new masks in order.
//  rst_n (synchronous, active low) empties both registers and zeroes the masks.
//  A stalled result is held; with the input register full, in_stall rises.
// ----------------------------------------------------------------------------
module dual_core_interrupt_controller_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [11:0] in_reg_offset,
  input  logic [2:0]  in_access_size,
  input  logic [31:0] in_write_data,
  input  logic [31:0] in_cpu_low_pending,
  input  logic [31:0] in_cop_low_pending,
  input  logic [31:0] in_cpu_high_pending,
  input  logic [31:0] in_cop_high_pending,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_read_data,
  output logic        out_cpu_irq,
  output logic        out_cop_irq
);

  // Input register
  logic                                 s1_valid_r;
  dcic_pkg::cmd_t                       s1_cmd_r;
  logic [dcic_pkg::OFFS_W-1:0]          s1_off_r;
  logic [dcic_pkg::SIZE_W-1:0]          s1_size_r;
  logic [dcic_pkg::DATA_W-1:0]          s1_data_r;
  logic [dcic_pkg::DATA_W-1:0]          s1_cpu_lo_r;
  logic [dcic_pkg::DATA_W-1:0]          s1_cop_lo_r;
  logic [dcic_pkg::DATA_W-1:0]          s1_cpu_hi_r;
  logic [dcic_pkg::DATA_W-1:0]          s1_cop_hi_r;

  // Enable state
  dcic_pkg::enables_t                   en_r;
  dcic_pkg::enables_t                   en_nxt;

  // Result register
  logic                                 out_valid_r;
  logic [dcic_pkg::DATA_W-1:0]          rdata_r;
  logic [dcic_pkg::DATA_W-1:0]          rdata_nxt;
  logic                                 cpu_irq_r;
  logic                                 cpu_irq_nxt;
  logic                                 cop_irq_r;
  logic                                 cop_irq_nxt;

  logic                                 out_load;
  logic                                 s1_load;
  logic [dcic_pkg::DATA_W-1:0]          word;
  logic [dcic_pkg::DATA_W-1:0]          size_mask;

  // Advance when the result register is free or being drained
  assign out_load = !out_valid_r || !out_stall;
  assign s1_load  = !s1_valid_r || out_load;
  assign in_stall = !s1_load;

  // Capture the incoming request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_load) begin
      s1_valid_r <= in_valid;
    end
    if (s1_load && in_valid) begin
      s1_cmd_r    <= dcic_pkg::cmd_t'(in_command);
      s1_off_r    <= in_reg_offset;
      s1_size_r   <= in_access_size;
      s1_data_r   <= in_write_data;
      s1_cpu_lo_r <= in_cpu_low_pending;
      s1_cop_lo_r <= in_cop_low_pending;
      s1_cpu_hi_r <= in_cpu_high_pending;
      s1_cop_hi_r <= in_cop_high_pending;
    end
  end

  // Select the addressed register word
  always_comb begin
    case ({s1_off_r[dcic_pkg::OFFS_W-1:2], 2'b00})
      dcic_pkg::OFF_CPU_LO_STAT:
        word = s1_cpu_lo_r | dcic_pkg::high_summary(s1_cpu_hi_r);
      dcic_pkg::OFF_COP_LO_STAT:
        word = s1_cop_lo_r | dcic_pkg::high_summary(s1_cop_hi_r);
      dcic_pkg::OFF_ALL_LO_STAT:
        word = s1_cpu_lo_r | s1_cop_lo_r | dcic_pkg::high_summary(s1_cpu_hi_r)
               | dcic_pkg::high_summary(s1_cop_hi_r);
      dcic_pkg::OFF_CPU_LO_EN, dcic_pkg::OFF_CPU_LO_SET, dcic_pkg::OFF_CPU_LO_CLR:
        word = en_r.cpu_lo;
      dcic_pkg::OFF_COP_LO_EN, dcic_pkg::OFF_COP_LO_SET, dcic_pkg::OFF_COP_LO_CLR:
        word = en_r.cop_lo;
      dcic_pkg::OFF_CPU_HI_STAT: word = s1_cpu_hi_r;
      dcic_pkg::OFF_COP_HI_STAT: word = s1_cop_hi_r;
      dcic_pkg::OFF_ALL_HI_STAT: word = s1_cpu_hi_r | s1_cop_hi_r;
      dcic_pkg::OFF_CPU_HI_EN, dcic_pkg::OFF_CPU_HI_SET, dcic_pkg::OFF_CPU_HI_CLR:
        word = en_r.cpu_hi;
      dcic_pkg::OFF_COP_HI_EN, dcic_pkg::OFF_COP_HI_SET, dcic_pkg::OFF_COP_HI_CLR:
        word = en_r.cop_hi;
      default: word = '0;
    endcase
  end

  // Narrow the read to the access size
  always_comb begin
    case (s1_size_r)
      dcic_pkg::SIZE_BYTE: size_mask = dcic_pkg::MASK_BYTE;
      dcic_pkg::SIZE_HALF: size_mask = dcic_pkg::MASK_HALF;
      default:             size_mask = dcic_pkg::MASK_WORD;
    endcase
  end

  // Build the result and the next enable masks
  always_comb begin
    rdata_nxt   = '0;
    cpu_irq_nxt = 1'b0;
    cop_irq_nxt = 1'b0;
    en_nxt      = en_r;
    case (s1_cmd_r)
      dcic_pkg::CMD_READ: begin
        rdata_nxt = (word >> {s1_off_r[1:0], 3'b000}) & size_mask;
      end
      dcic_pkg::CMD_WRITE: begin
        case (s1_off_r)
          dcic_pkg::OFF_CPU_LO_SET: en_nxt.cpu_lo = en_r.cpu_lo | s1_data_r;
          dcic_pkg::OFF_CPU_LO_CLR: en_nxt.cpu_lo = en_r.cpu_lo & ~s1_data_r;
          dcic_pkg::OFF_COP_LO_SET: en_nxt.cop_lo = en_r.cop_lo | s1_data_r;
          dcic_pkg::OFF_COP_LO_CLR: en_nxt.cop_lo = en_r.cop_lo & ~s1_data_r;
          dcic_pkg::OFF_CPU_HI_SET: en_nxt.cpu_hi = en_r.cpu_hi | s1_data_r;
          dcic_pkg::OFF_CPU_HI_CLR: en_nxt.cpu_hi = en_r.cpu_hi & ~s1_data_r;
          dcic_pkg::OFF_COP_HI_SET: en_nxt.cop_hi = en_r.cop_hi | s1_data_r;
          dcic_pkg::OFF_COP_HI_CLR: en_nxt.cop_hi = en_r.cop_hi & ~s1_data_r;
          default: en_nxt = en_r;
        endcase
      end
      dcic_pkg::CMD_TICK: begin
        cpu_irq_nxt = dcic_pkg::core_flag(s1_cpu_lo_r, en_r.cpu_lo,
                                          s1_cpu_hi_r, en_r.cpu_hi);
        cop_irq_nxt = dcic_pkg::core_flag(s1_cop_lo_r, en_r.cop_lo,
                                          s1_cop_hi_r, en_r.cop_hi);
      end
      default: begin
        rdata_nxt = '0;
      end
    endcase
  end

  // Commit enables and load the result as the request advances
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r        <= '0;
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= s1_valid_r;
      if (s1_valid_r) begin
        en_r <= en_nxt;
      end
    end
    if (out_load && s1_valid_r) begin
      rdata_r   <= rdata_nxt;
      cpu_irq_r <= cpu_irq_nxt;
      cop_irq_r <= cop_irq_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = rdata_r;
  assign out_cpu_irq   = cpu_irq_r;
  assign out_cop_irq   = cop_irq_r;

`ifndef NO_ASSERTIONS
  // Read data and interrupt flags never come from the same request
  a_rd_irq_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (rdata_r != '0) |-> !cpu_irq_r && !cop_irq_r)
    else $error("read data and irq flag in one result");

  // Input side stalls only with a request held in the input register
  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r && out_stall)
    else $error("input stalled without a blocked request");

  // Enable masks change only on a write that advances
  a_en_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_load && s1_valid_r && (s1_cmd_r == dcic_pkg::CMD_WRITE)) |=> $stable(en_r))
    else $error("enable masks changed without a write");

  // A request leaving the input register lands in the result register
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_load |=> out_valid_r)
    else $error("request lost between stages");
`endif

endmodule

### tb/sv/dual_core_interrupt_controller_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_core_interrupt_controller_unit_test: self-checking bench for the
// dual-core interrupt controller.
// Drives register reads, set/clear writes, ticks and idle commands with
// random status words and random gaps and stalls on both channels. A
// scoreboard tracks the four enable masks, predicts every response in
// request order and compares it field by field.
// ----------------------------------------------------------------------------

typedef struct packed {
  dcic_pkg::cmd_t command;
  logic [11:0]    reg_offset;
  logic [2:0]     access_size;
  logic [31:0]    write_data;
  logic [31:0]    cpu_low_pending;
  logic [31:0]    cop_low_pending;
  logic [31:0]    cpu_high_pending;
  logic [31:0]    cop_high_pending;
} intc_request_t;

typedef struct packed {
  logic [31:0] read_data;
  logic        cpu_irq;
  logic        cop_irq;
} intc_response_t;

class intc_scoreboard;
  logic [31:0]    cpu_lo_en;
  logic [31:0]    cop_lo_en;
  logic [31:0]    cpu_hi_en;
  logic [31:0]    cop_hi_en;
  intc_response_t awaited_responses[$];
  int unsigned    mismatches;

  function new();
    cpu_lo_en  = '0;
    cop_lo_en  = '0;
    cpu_hi_en  = '0;
    cop_hi_en  = '0;
    mismatches = 0;
  endfunction

  // Compute the response of one request and apply its effect on the masks
  function intc_response_t predict_response(intc_request_t r);
    intc_response_t resp;
    logic [31:0]    word;
    logic [31:0]    sum_bit;
    logic [31:0]    cpu_sum;
    logic [31:0]    cop_sum;
    logic [31:0]    lane_mask;
    logic [11:0]    aligned;
    resp    = '0;
    sum_bit = 32'd1 << dcic_pkg::SUMMARY_IDX;
    cpu_sum = (r.cpu_high_pending != 0) ? sum_bit : 32'd0;
    cop_sum = (r.cop_high_pending != 0) ? sum_bit : 32'd0;
    aligned = {r.reg_offset[11:2], 2'b00};
    case (r.command)
      dcic_pkg::CMD_READ: begin
        case (aligned)
          dcic_pkg::OFF_CPU_LO_STAT: word = r.cpu_low_pending | cpu_sum;
          dcic_pkg::OFF_COP_LO_STAT: word = r.cop_low_pending | cop_sum;
          dcic_pkg::OFF_ALL_LO_STAT:
            word = r.cpu_low_pending | r.cop_low_pending | cpu_sum | cop_sum;
          dcic_pkg::OFF_CPU_LO_EN, dcic_pkg::OFF_CPU_LO_SET, dcic_pkg::OFF_CPU_LO_CLR:
            word = cpu_lo_en;
          dcic_pkg::OFF_COP_LO_EN, dcic_pkg::OFF_COP_LO_SET, dcic_pkg::OFF_COP_LO_CLR:
            word = cop_lo_en;
          dcic_pkg::OFF_CPU_HI_STAT: word = r.cpu_high_pending;
          dcic_pkg::OFF_COP_HI_STAT: word = r.cop_high_pending;
          dcic_pkg::OFF_ALL_HI_STAT: word = r.cpu_high_pending | r.cop_high_pending;
          dcic_pkg::OFF_CPU_HI_EN, dcic_pkg::OFF_CPU_HI_SET, dcic_pkg::OFF_CPU_HI_CLR:
            word = cpu_hi_en;
          dcic_pkg::OFF_COP_HI_EN, dcic_pkg::OFF_COP_HI_SET, dcic_pkg::OFF_COP_HI_CLR:
            word = cop_hi_en;
          default: word = '0;
        endcase
        case (r.access_size)
          dcic_pkg::SIZE_BYTE: lane_mask = dcic_pkg::MASK_BYTE;
          dcic_pkg::SIZE_HALF: lane_mask = dcic_pkg::MASK_HALF;
          default:             lane_mask = dcic_pkg::MASK_WORD;
        endcase
        resp.read_data = (word >> (8 * r.reg_offset[1:0])) & lane_mask;
      end
      dcic_pkg::CMD_WRITE: begin
        // Only exact set/clear offsets touch the masks
        case (r.reg_offset)
          dcic_pkg::OFF_CPU_LO_SET: cpu_lo_en = cpu_lo_en | r.write_data;
          dcic_pkg::OFF_CPU_LO_CLR: cpu_lo_en = cpu_lo_en & ~r.write_data;
          dcic_pkg::OFF_COP_LO_SET: cop_lo_en = cop_lo_en | r.write_data;
          dcic_pkg::OFF_COP_LO_CLR: cop_lo_en = cop_lo_en & ~r.write_data;
          dcic_pkg::OFF_CPU_HI_SET: cpu_hi_en = cpu_hi_en | r.write_data;
          dcic_pkg::OFF_CPU_HI_CLR: cpu_hi_en = cpu_hi_en & ~r.write_data;
          dcic_pkg::OFF_COP_HI_SET: cop_hi_en = cop_hi_en | r.write_data;
          dcic_pkg::OFF_COP_HI_CLR: cop_hi_en = cop_hi_en & ~r.write_data;
          default: ;
        endcase
      end
      dcic_pkg::CMD_TICK: begin
        // Low bank directly, high bank only through enable bit 30
        resp.cpu_irq = ((r.cpu_low_pending & cpu_lo_en) != 0) ||
                       (cpu_lo_en[dcic_pkg::SUMMARY_IDX] &&
                        ((r.cpu_high_pending & cpu_hi_en) != 0));
        resp.cop_irq = ((r.cop_low_pending & cop_lo_en) != 0) ||
                       (cop_lo_en[dcic_pkg::SUMMARY_IDX] &&
                        ((r.cop_high_pending & cop_hi_en) != 0));
      end
      default: ;
    endcase
    return resp;
  endfunction

  function void note_request(intc_request_t r);
    awaited_responses.push_back(predict_response(r));
  endfunction

  task report(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t ns: mismatch on %s: got %h, want %h", $time, what, got, want);
    mismatches++;
  endtask

  task check_result(intc_response_t got);
    intc_response_t want;
    if (awaited_responses.size() == 0) begin
      report("unexpected response", got.read_data, '0);
    end else begin
      want = awaited_responses.pop_front();
      if (got.read_data !== want.read_data) report("read_data", got.read_data, want.read_data);
      if (got.cpu_irq !== want.cpu_irq) report("cpu_irq", 32'(got.cpu_irq), 32'(want.cpu_irq));
      if (got.cop_irq !== want.cop_irq) report("cop_irq", 32'(got.cop_irq), 32'(want.cop_irq));
    end
  endtask
endclass

module dual_core_interrupt_controller_unit_test;

  localparam logic [11:0] WRITE_TARGETS [8] = '{
    dcic_pkg::OFF_CPU_LO_SET, dcic_pkg::OFF_CPU_LO_CLR,
    dcic_pkg::OFF_COP_LO_SET, dcic_pkg::OFF_COP_LO_CLR,
    dcic_pkg::OFF_CPU_HI_SET, dcic_pkg::OFF_CPU_HI_CLR,
    dcic_pkg::OFF_COP_HI_SET, dcic_pkg::OFF_COP_HI_CLR
  };
  localparam logic [11:0] READ_TARGETS [18] = '{
    dcic_pkg::OFF_CPU_LO_STAT, dcic_pkg::OFF_COP_LO_STAT, dcic_pkg::OFF_ALL_LO_STAT,
    dcic_pkg::OFF_CPU_LO_EN, dcic_pkg::OFF_CPU_LO_SET, dcic_pkg::OFF_CPU_LO_CLR,
    dcic_pkg::OFF_COP_LO_EN, dcic_pkg::OFF_COP_LO_SET, dcic_pkg::OFF_COP_LO_CLR,
    dcic_pkg::OFF_CPU_HI_STAT, dcic_pkg::OFF_COP_HI_STAT, dcic_pkg::OFF_ALL_HI_STAT,
    dcic_pkg::OFF_CPU_HI_EN, dcic_pkg::OFF_CPU_HI_SET, dcic_pkg::OFF_CPU_HI_CLR,
    dcic_pkg::OFF_COP_HI_EN, dcic_pkg::OFF_COP_HI_SET, dcic_pkg::OFF_COP_HI_CLR
  };
  localparam int unsigned HOLD_OFF_CYCLES = 120;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_command = dcic_pkg::CMD_NONE;
  logic [11:0] in_reg_offset = '0;
  logic [2:0]  in_access_size = '0;
  logic [31:0] in_write_data = '0;
  logic [31:0] in_cpu_low_pending = '0;
  logic [31:0] in_cop_low_pending = '0;
  logic [31:0] in_cpu_high_pending = '0;
  logic [31:0] in_cop_high_pending = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_read_data;
  logic        out_cpu_irq;
  logic        out_cop_irq;

  bit             sender_gaps_off = 1'b0;
  bit             hold_off_req = 1'b0;
  intc_scoreboard tracker = new();

  dual_core_interrupt_controller_unit uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_command          (in_command),
    .in_reg_offset       (in_reg_offset),
    .in_access_size      (in_access_size),
    .in_write_data       (in_write_data),
    .in_cpu_low_pending  (in_cpu_low_pending),
    .in_cop_low_pending  (in_cop_low_pending),
    .in_cpu_high_pending (in_cpu_high_pending),
    .in_cop_high_pending (in_cop_high_pending),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_read_data       (out_read_data),
    .out_cpu_irq         (out_cpu_irq),
    .out_cop_irq         (out_cop_irq)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Sample both channels at the same edge: note requests, then check responses
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        tracker.note_request('{dcic_pkg::cmd_t'(in_command), in_reg_offset,
                               in_access_size, in_write_data, in_cpu_low_pending,
                               in_cop_low_pending, in_cpu_high_pending,
                               in_cop_high_pending});
      end
      if (out_valid && !out_stall) begin
        tracker.check_result('{out_read_data, out_cpu_irq, out_cop_irq});
      end
    end
  end

  // Mostly sparse words so that enabled-pending matches stay uncommon
  function automatic logic [31:0] status_word();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0:       return '0;
      1:       return '1;
      2, 3:    return 32'd1 << $urandom_range(0, 31);
      4, 5:    return $urandom;
      default: return $urandom & $urandom & $urandom;
    endcase
  endfunction

  function automatic int unsigned sender_gap();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (sender_gaps_off || pick < 55) return 0;
    if (pick < 85) return $urandom_range(1, 2);
    if (pick < 95) return $urandom_range(3, 8);
    return $urandom_range(12, 40);
  endfunction

  // Idle for a random gap, then offer one request and hold it until taken
  task automatic send_request(dcic_pkg::cmd_t cmd, logic [11:0] offs, logic [2:0] size,
                              logic [31:0] data, logic [31:0] cpu_lo, logic [31:0] cop_lo,
                              logic [31:0] cpu_hi, logic [31:0] cop_hi);
    int unsigned gap;
    gap = sender_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_command          <= cmd;
    in_reg_offset       <= offs;
    in_access_size      <= size;
    in_write_data       <= data;
    in_cpu_low_pending  <= cpu_lo;
    in_cop_low_pending  <= cop_lo;
    in_cpu_high_pending <= cpu_hi;
    in_cop_high_pending <= cop_hi;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic run_random_requests(int unsigned count);
    int unsigned    kind;
    logic [11:0]    offs;
    logic [2:0]     size;
    dcic_pkg::cmd_t cmd;
    for (int unsigned i = 0; i < count; i++) begin
      kind = $urandom_range(0, 99);
      size = 3'($urandom_range(0, 7));
      if ($urandom_range(0, 1)) begin
        size = ($urandom_range(0, 1)) ? dcic_pkg::SIZE_BYTE : dcic_pkg::SIZE_HALF;
      end
      if (kind < 35) begin
        cmd  = dcic_pkg::CMD_WRITE;
        offs = WRITE_TARGETS[$urandom_range(0, 7)];
      end else if (kind < 65) begin
        cmd  = dcic_pkg::CMD_READ;
        offs = READ_TARGETS[$urandom_range(0, 17)] | 12'($urandom_range(0, 3));
      end else if (kind < 90) begin
        cmd  = dcic_pkg::CMD_TICK;
        offs = 12'($urandom_range(0, 4095));
      end else if (kind < 96) begin
        cmd  = ($urandom_range(0, 1)) ? dcic_pkg::CMD_WRITE : dcic_pkg::CMD_READ;
        offs = 12'($urandom_range(0, 4095));
      end else begin
        cmd  = dcic_pkg::CMD_NONE;
        offs = 12'($urandom_range(0, 4095));
      end
      send_request(cmd, offs, size, status_word(), status_word(), status_word(),
                   status_word(), status_word());
    end
  endtask

  // Receiver: random stalls, plus a long hold-off on request
  initial begin
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      int unsigned pick;
      int unsigned len;
      if (hold_off_req) begin
        out_stall <= 1'b1;
        for (int unsigned n = 0; n < HOLD_OFF_CYCLES; n++) @(posedge clk);
        hold_off_req = 1'b0;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          out_stall <= 1'b0;
          len = $urandom_range(1, 30);
        end else if (pick < 80) begin
          out_stall <= 1'b1;
          len = $urandom_range(1, 2);
        end else if (pick < 95) begin
          out_stall <= 1'b0;
          len = 1;
        end else begin
          out_stall <= 1'b1;
          len = $urandom_range(8, 40);
        end
        repeat (len) @(posedge clk);
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: status reads at extremes, mask set/clear, both tick paths
    send_request(dcic_pkg::CMD_READ, dcic_pkg::OFF_CPU_LO_STAT, 3'd4, '0, '1, '1, '1, '1);
    send_request(dcic_pkg::CMD_READ, dcic_pkg::OFF_COP_LO_STAT + 12'd1, dcic_pkg::SIZE_BYTE,
                 '0, '0, '0, '0, 32'h8000_0000);
    send_request(dcic_pkg::CMD_READ, dcic_pkg::OFF_ALL_LO_STAT + 12'd2, dcic_pkg::SIZE_HALF,
                 '0, 32'h0000_1234, 32'h5678_0000, 32'h1, '0);
    send_request(dcic_pkg::CMD_WRITE, dcic_pkg::OFF_CPU_LO_SET, 3'd4, '1, '0, '0, '0, '0);
    send_request(dcic_pkg::CMD_TICK, '0, '0, '0, 32'h0000_0002, '0, '0, '0);
    send_request(dcic_pkg::CMD_WRITE, dcic_pkg::OFF_COP_LO_SET, dcic_pkg::SIZE_BYTE,
                 32'h4000_0001, '0, '0, '0, '0);
    send_request(dcic_pkg::CMD_WRITE, dcic_pkg::OFF_CPU_HI_SET, dcic_pkg::SIZE_HALF,
                 32'h0000_0001, '0, '0, '0, '0);
    send_request(dcic_pkg::CMD_WRITE, dcic_pkg::OFF_COP_HI_SET, 3'd0,
                 32'h8000_0000, '0, '0, '0, '0);
    send_request(dcic_pkg::CMD_TICK, '0, '0, '0, '0, '0, 32'h0000_0001, 32'h8000_0000);
    send_request(dcic_pkg::CMD_WRITE, dcic_pkg::OFF_CPU_LO_CLR, 3'd4,
                 32'h4000_0000, '0, '0, '0, '0);
    send_request(dcic_pkg::CMD_TICK, '0, '0, '0, '0, '0, 32'h0000_0001, 32'h8000_0000);
    // Writes off the exact set/clear offsets must be dropped
    send_request(dcic_pkg::CMD_WRITE, dcic_pkg::OFF_CPU_LO_SET + 12'd1, 3'd4,
                 '1, '0, '0, '0, '0);
    send_request(dcic_pkg::CMD_WRITE, dcic_pkg::OFF_CPU_LO_EN, 3'd4, '1, '0, '0, '0, '0);
    send_request(dcic_pkg::CMD_READ, dcic_pkg::OFF_CPU_LO_EN + 12'd3, dcic_pkg::SIZE_BYTE,
                 '0, '0, '0, '0, '0);
    // Odd access sizes read as full words
    send_request(dcic_pkg::CMD_READ, dcic_pkg::OFF_CPU_LO_SET, 3'd0, '0, '0, '0, '0, '0);
    send_request(dcic_pkg::CMD_READ, dcic_pkg::OFF_COP_LO_CLR, 3'd7, '0, '0, '0, '0, '0);
    send_request(dcic_pkg::CMD_READ, dcic_pkg::OFF_CPU_HI_STAT, 3'd3,
                 '0, '0, '0, 32'hdead_beef, '0);
    send_request(dcic_pkg::CMD_READ, dcic_pkg::OFF_COP_HI_STAT + 12'd1, 3'd5,
                 '0, '0, '0, '0, 32'hcafe_f00d);
    send_request(dcic_pkg::CMD_READ, dcic_pkg::OFF_ALL_HI_STAT, 3'd6,
                 '0, '0, '0, 32'h0f0f_0000, 32'h0000_f0f0);
    send_request(dcic_pkg::CMD_READ, dcic_pkg::OFF_CPU_HI_CLR, 3'd4, '0, '0, '0, '0, '0);
    send_request(dcic_pkg::CMD_READ, dcic_pkg::OFF_COP_HI_EN + 12'd2, dcic_pkg::SIZE_HALF,
                 '0, '0, '0, '0, '0);
    send_request(dcic_pkg::CMD_READ, 12'hfff, 3'd4, '1, '1, '1, '1, '1);
    // Unused command leaves the masks alone and returns zeros
    send_request(dcic_pkg::CMD_NONE, dcic_pkg::OFF_COP_LO_SET, 3'd7, '1, '1, '1, '1, '1);
    send_request(dcic_pkg::CMD_WRITE, dcic_pkg::OFF_COP_LO_CLR, 3'd4, '1, '0, '0, '0, '0);
    send_request(dcic_pkg::CMD_WRITE, dcic_pkg::OFF_COP_HI_CLR, 3'd4, '1, '0, '0, '0, '0);
    send_request(dcic_pkg::CMD_WRITE, dcic_pkg::OFF_CPU_HI_CLR, 3'd4, '1, '0, '0, '0, '0);

    // Random traffic with a back-to-back stretch and a receiver hold-off
    run_random_requests(250);
    sender_gaps_off = 1'b1;
    run_random_requests(60);
    hold_off_req = 1'b1;
    run_random_requests(40);
    sender_gaps_off = 1'b0;
    run_random_requests(350);
    in_valid <= 1'b0;

    // Drain the responses still in flight
    while (tracker.awaited_responses.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.awaited_responses.size() == 0) begin
      $display("dual_core_interrupt_controller_unit_test: clean");
    end else begin
      $display("dual_core_interrupt_controller_unit_test: errors");
    end
    $finish;
  end

  // Hard limit on run time
  initial begin
    #5_000_000;
    $display("dual_core_interrupt_controller_unit_test: errors");
    $finish;
  end

endmodule

### dual_core_interrupt_controller_unit.f
hdl/dcic_pkg.sv
hdl/dual_core_interrupt_controller_unit.sv
tb/sv/dual_core_interrupt_controller_unit_test.sv
